// ----- hdl/gfsd_pkg.sv -----
package gfsd_pkg;

  // Frame geometry
  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Diffused error entry width (largest share sum is 6)
  localparam int ERR_W = 3;

  // Luma weights, Q0.16, summing to 65536
  localparam int LUMA_W    = 8;
  localparam int PROD_W    = 24;
  localparam int SUM_W     = PROD_W + 2;
  localparam int W_RED     = 13933;
  localparam int W_GREEN   = 46871;
  localparam int W_BLUE    = 4732;

  // Configuration port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;

  // Reset geometry: 640 x 480, stored as last column / last row
  localparam logic [COL_W-1:0] COL_LAST_RST = COL_W'(640 - 1);
  localparam logic [ROW_W-1:0] ROW_LAST_RST = ROW_W'(480 - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_t;

  typedef struct packed {
    logic [7:0] gray_level;
    logic       frame_end;
  } out_t;

  // Raster position of the pixel in the compute stage
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             first_col;
    logic             last_col;
    logic             first_row;
    logic             last_row;
  } pos_t;

  // Write request into the error line
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [ERR_W-1:0] data;
  } line_wr_t;

endpackage

// ----- hdl/gfsd_line_mem.sv -----
module gfsd_line_mem (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [gfsd_pkg::COL_W-1:0] rd_addr,
  input  gfsd_pkg::line_wr_t         wr,
  output logic [gfsd_pkg::ERR_W-1:0] rd_data
);

  logic [gfsd_pkg::ERR_W-1:0] mem [gfsd_pkg::MAX_WIDTH];
  logic [gfsd_pkg::ERR_W-1:0] q_r;
  logic                       fwd_hit_r;
  logic [gfsd_pkg::ERR_W-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read-first array; a same-cycle write to the read address is bypassed
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_hit_r  <= wr.en && (wr.addr == rd_addr);
      fwd_data_r <= wr.data;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : q_r;

endmodule

// ----- hdl/gfsd_diffuse.sv -----
module gfsd_diffuse (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic                        step,
  input  logic [gfsd_pkg::LUMA_W-1:0] luma,
  input  logic [gfsd_pkg::ERR_W-1:0]  line_err,
  input  gfsd_pkg::pos_t              pos,
  input  logic [gfsd_pkg::COL_W-1:0]  col_last,
  output logic [7:0]                  level,
  output gfsd_pkg::line_wr_t          line_wr
);

  logic [gfsd_pkg::ERR_W-1:0] carry_r, carry_nxt;
  logic [gfsd_pkg::ERR_W-1:0] pend_r, pend_nxt;
  logic [gfsd_pkg::ERR_W-1:0] incoming;
  logic [8:0]                 v_sum;
  logic [7:0]                 v_sat;
  logic [3:0]                 err;
  logic [6:0]                 e7;
  logic [5:0]                 e3;
  logic [6:0]                 e5;
  logic [2:0]                 s7;
  logic [1:0]                 s3;
  logic [2:0]                 s5;
  logic [3:0]                 below_left;

  // Row 0 never sees line contents. With a one-pixel row the entry this
  // pixel reads is the one written from pend_r in this same step.
  always_comb begin
    if (pos.first_row) begin
      incoming = '0;
    end else if (pos.first_col && pos.last_col) begin
      incoming = pend_r;
    end else begin
      incoming = line_err;
    end
  end

  always_comb begin
    v_sum = 9'(luma) + 9'(incoming) + 9'(carry_r);
    v_sat = v_sum[8] ? 8'hFF : v_sum[7:0];
    err   = v_sat[3:0];
    level = {v_sat[7:4], 4'b0000};
    e7    = 7'(err) * 7'd7;
    e3    = 6'(err) * 6'd3;
    e5    = 7'(err) * 7'd5;
    s7    = e7[6:4];
    s3    = e3[5:4];
    s5    = e5[6:4];
  end

  // The 1/16 share is always zero for a remainder below 16.
  always_comb begin
    carry_nxt  = pos.last_col ? '0 : s7;
    pend_nxt   = s5;
    below_left = 4'(pend_r) + 4'(s3);
  end

  // One write per pixel: column-1 gets its finished sum; at column 0 the
  // previous row's last-column share is written late.
  always_comb begin
    line_wr.en   = step;
    line_wr.addr = pos.first_col ? col_last : pos.col - 1'b1;
    line_wr.data = pos.first_col ? pend_r : below_left[gfsd_pkg::ERR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      carry_r <= '0;
      pend_r  <= '0;
    end else if (step) begin
      carry_r <= carry_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

// ----- hdl/gray_floyd_steinberg_dither_core.sv -----
// Channel | Ports                                   | Request moves
// --------+-----------------------------------------+--------------------------------
// in      | in_valid, in_ready, in_data (in_t)      | one RGB pixel, raster order
// out     | out_valid, out_ready, out_data (out_t)  | gray level and frame_end flag
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | image_width / image_height
//
// Throughput is one pixel per clock while out is not stalled; a taken request
// reaches out in order: accept registers products and reads the line, then
// compute writes the output register.
// The single read port of the error line memory sets that rate: one read and
// one write per pixel.
// Reset (rst_n, synchronous) and any register write restart the frame at the
// top left; the line memory holds no reset value, row 0 ignores it instead.
// A stalled out side holds one result in the output register and one pixel in
// the compute stage before in_ready drops.
module gray_floyd_steinberg_dither_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gfsd_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gfsd_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gfsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gfsd_pkg::CFG_DATA_W-1:0] cfg_data
);

  // geometry, kept as last column / last row after clamping
  logic [gfsd_pkg::COL_W-1:0] col_last_r, col_last_nxt;
  logic [gfsd_pkg::ROW_W-1:0] row_last_r, row_last_nxt;
  logic                       cfg_clear;

  // raster position of the next request
  logic [gfsd_pkg::COL_W-1:0] col_r, col_nxt;
  logic [gfsd_pkg::ROW_W-1:0] row_r, row_nxt;

  // compute stage
  logic                        s1_valid_r, s1_valid_nxt;
  logic [gfsd_pkg::PROD_W-1:0] prod_r_r, prod_g_r, prod_b_r;
  gfsd_pkg::pos_t              s1_pos_r, pos_now;
  logic [gfsd_pkg::SUM_W-1:0]  luma_sum;
  logic [gfsd_pkg::LUMA_W-1:0] luma;

  // output register
  logic           out_valid_r, out_valid_nxt;
  gfsd_pkg::out_t out_data_r;

  logic                       in_fire;
  logic                       adv;
  logic [gfsd_pkg::ERR_W-1:0] line_err;
  logic [7:0]                 level;
  gfsd_pkg::line_wr_t         line_wr;

  logic [gfsd_pkg::WIDTH_REG_W-1:0]  w_val;
  logic [gfsd_pkg::HEIGHT_REG_W-1:0] h_val;

  // ---------------------------------------------------------------------
  // Handshake: compute stage advances when the output register is free or
  // being drained; input is taken whenever the compute stage will be empty.
  // ---------------------------------------------------------------------
  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // Configuration: clamp out-of-range sizes, store last index directly.
  // An index beyond the list is dropped and does not restart the frame.
  // ---------------------------------------------------------------------
  assign w_val = cfg_data[gfsd_pkg::WIDTH_REG_W-1:0];
  assign h_val = cfg_data[gfsd_pkg::HEIGHT_REG_W-1:0];

  always_comb begin
    col_last_nxt = col_last_r;
    row_last_nxt = row_last_r;
    cfg_clear    = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        gfsd_pkg::CFG_IMAGE_WIDTH: begin
          cfg_clear = 1'b1;
          if (w_val == '0) begin
            col_last_nxt = '0;
          end else if (int'(w_val) > gfsd_pkg::MAX_WIDTH) begin
            col_last_nxt = gfsd_pkg::COL_W'(gfsd_pkg::MAX_WIDTH - 1);
          end else begin
            col_last_nxt = gfsd_pkg::COL_W'(w_val - 1'b1);
          end
        end
        gfsd_pkg::CFG_IMAGE_HEIGHT: begin
          cfg_clear = 1'b1;
          if (h_val == '0) begin
            row_last_nxt = '0;
          end else if (int'(h_val) > gfsd_pkg::MAX_HEIGHT) begin
            row_last_nxt = gfsd_pkg::ROW_W'(gfsd_pkg::MAX_HEIGHT - 1);
          end else begin
            row_last_nxt = gfsd_pkg::ROW_W'(h_val - 1'b1);
          end
        end
        default: begin
          cfg_clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_last_r <= gfsd_pkg::COL_LAST_RST;
      row_last_r <= gfsd_pkg::ROW_LAST_RST;
    end else begin
      col_last_r <= col_last_nxt;
      row_last_r <= row_last_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Raster counters advance on accept; they address the line read.
  // ---------------------------------------------------------------------
  always_comb begin
    pos_now.col       = col_r;
    pos_now.first_col = (col_r == '0);
    pos_now.last_col  = (col_r == col_last_r);
    pos_now.first_row = (row_r == '0);
    pos_now.last_row  = (row_r == row_last_r);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_clear) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire) begin
      if (pos_now.last_col) begin
        col_nxt = '0;
        row_nxt = pos_now.last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Accept stage: weight products registered, position captured.
  // ---------------------------------------------------------------------
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      prod_r_r <= gfsd_pkg::PROD_W'(gfsd_pkg::W_RED)   * gfsd_pkg::PROD_W'(in_data.red);
      prod_g_r <= gfsd_pkg::PROD_W'(gfsd_pkg::W_GREEN) * gfsd_pkg::PROD_W'(in_data.green);
      prod_b_r <= gfsd_pkg::PROD_W'(gfsd_pkg::W_BLUE)  * gfsd_pkg::PROD_W'(in_data.blue);
      s1_pos_r <= pos_now;
    end
  end

  // weights sum to 65536, so the truncated luma fits eight bits
  assign luma_sum = gfsd_pkg::SUM_W'(prod_r_r) + gfsd_pkg::SUM_W'(prod_g_r)
                  + gfsd_pkg::SUM_W'(prod_b_r);
  assign luma     = luma_sum[23:16];

  // ---------------------------------------------------------------------
  // Error line: read at accept, written when the pixel leaves compute.
  // ---------------------------------------------------------------------
  gfsd_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_r),
    .wr      (line_wr),
    .rd_data (line_err)
  );

  gfsd_diffuse u_diffuse (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (cfg_clear),
    .step     (adv),
    .luma     (luma),
    .line_err (line_err),
    .pos      (s1_pos_r),
    .col_last (col_last_r),
    .level    (level),
    .line_wr  (line_wr)
  );

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.gray_level <= level;
      out_data_r.frame_end  <= s1_pos_r.last_col && s1_pos_r.last_row;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= col_last_r) && (row_r <= row_last_r))
    else $error("raster position outside configured frame");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && pos_now.last_col && pos_now.last_row) |=> (col_r == '0 && row_r == '0))
    else $error("position did not wrap after last pixel");

  a_wr_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    line_wr.en |-> (line_wr.addr <= col_last_r))
    else $error("error line write beyond row width");

  a_level_grid: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_valid_r && out_data_r.gray_level[3:0] == 4'b0000))
    else $error("result not on a 16-level step");
`endif

endmodule
